// ===== rtl/max_pool_2x2_stride2_defines.svh =====
// Assertion macros shared by the max pooling block.
`ifndef MAX_POOL_2X2_STRIDE2_DEFINES_SVH
`define MAX_POOL_2X2_STRIDE2_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("max pool assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("max pool assertion failed");

`endif

// ===== rtl/mp_pkg.sv =====
// Shared types and constants of the 2x2 stride 2 max pooling block.
package mp_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Size limits of a feature map.
  localparam logic [6:0] HEIGHT_MIN  = 7'd2;
  localparam logic [6:0] HEIGHT_MAX  = 7'd64;
  localparam logic [6:0] WIDTH_MIN   = 7'd2;
  localparam logic [8:0] CHANNEL_MIN = 9'd1;
  localparam logic [8:0] CHANNEL_MAX = 9'd256;

  // Configuration values after reset.
  localparam logic [6:0] WIDTH_RESET   = 7'd26;
  localparam logic [6:0] HEIGHT_RESET  = 7'd26;
  localparam logic [8:0] CHANNEL_RESET = 9'd8;
  localparam logic signed [SAMPLE_W-1:0] FLOOR_RESET = -16'sd2560;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH      = 2'd0,
    REG_IN_HEIGHT     = 2'd1,
    REG_CHANNEL_COUNT = 2'd2,
    REG_FLOOR_VALUE   = 2'd3
  } cfg_reg_t;

  // What the back end does with a queued sample.
  typedef enum logic [1:0] {
    KIND_PAIR_FIRST = 2'd0,
    KIND_PAIR_STORE = 2'd1,
    KIND_PAIR_EMIT  = 2'd2
  } item_kind_t;

  // One classified sample travelling from the front end to the back end.
  typedef struct packed {
    item_kind_t                  kind;
    logic                        last;
    logic signed [SAMPLE_W-1:0]  sample;
  } pool_item_t;

  // Frame geometry as written by software, before clamping.
  typedef struct packed {
    logic [6:0] in_width;
    logic [6:0] in_height;
    logic [8:0] channel_count;
  } pool_cfg_t;

endpackage

// ===== rtl/mp_front.sv =====
// Front end: position counters and classification of each accepted sample.
module mp_front import mp_pkg::*; #(
  parameter int MAX_WIDTH = 64,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int SW = $clog2(MAX_WIDTH / 2)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pool_cfg_t                   cfg_i,
  input  logic                        in_accept_i,
  input  logic signed [SAMPLE_W-1:0]  in_sample_i,
  output logic                        push_o,
  output pool_item_t                  item_o,
  output logic [SW-1:0]               slot_o
);

  localparam int XW = CW + 1;

  logic [CW-1:0] col_r, col_nxt;
  logic [5:0]    row_r, row_nxt;
  logic [7:0]    chan_r, chan_nxt;

  logic [XW-1:0] width_eff;
  logic [XW-1:0] width_even;
  logic [6:0]    height_eff;
  logic [6:0]    height_even;
  logic [8:0]    chan_eff;
  logic [XW-1:0] col_inc;
  logic [6:0]    row_inc;
  logic [8:0]    chan_inc;
  logic          in_range;

  // Clamp the written geometry to the supported ranges.
  always_comb begin
    if (cfg_i.in_width < WIDTH_MIN) begin
      width_eff = XW'(2);
    end else if (32'(cfg_i.in_width) > MAX_WIDTH) begin
      width_eff = XW'(MAX_WIDTH);
    end else begin
      width_eff = XW'(cfg_i.in_width);
    end
    if (cfg_i.in_height < HEIGHT_MIN) begin
      height_eff = HEIGHT_MIN;
    end else if (cfg_i.in_height > HEIGHT_MAX) begin
      height_eff = HEIGHT_MAX;
    end else begin
      height_eff = cfg_i.in_height;
    end
    if (cfg_i.channel_count < CHANNEL_MIN) begin
      chan_eff = CHANNEL_MIN;
    end else if (cfg_i.channel_count > CHANNEL_MAX) begin
      chan_eff = CHANNEL_MAX;
    end else begin
      chan_eff = cfg_i.channel_count;
    end
  end

  // A trailing odd column or row lies outside the pooled area.
  assign width_even  = {width_eff[XW-1:1], 1'b0};
  assign height_even = {height_eff[6:1], 1'b0};
  assign col_inc     = {1'b0, col_r} + XW'(1);
  assign row_inc     = {1'b0, row_r} + 7'd1;
  assign chan_inc    = {1'b0, chan_r} + 9'd1;
  assign in_range    = ({1'b0, col_r} < width_even) && ({1'b0, row_r} < height_even);

  // Classify the sample by the parity of its column and row.
  always_comb begin
    push_o         = in_accept_i && in_range;
    item_o.sample  = in_sample_i;
    item_o.last    = (col_inc == width_even) && (row_inc == height_even);
    slot_o         = col_r[SW:1];
    if (!col_r[0]) begin
      item_o.kind = KIND_PAIR_FIRST;
    end else if (!row_r[0]) begin
      item_o.kind = KIND_PAIR_STORE;
    end else begin
      item_o.kind = KIND_PAIR_EMIT;
    end
  end

  // Advance column, row and channel; each wraps at or past its last value.
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    chan_nxt = chan_r;
    if (in_accept_i) begin
      if (col_inc >= width_eff) begin
        col_nxt = '0;
        if (row_inc >= height_eff) begin
          row_nxt = '0;
          if (chan_inc >= chan_eff) begin
            chan_nxt = '0;
          end else begin
            chan_nxt = chan_inc[7:0];
          end
        end else begin
          row_nxt = row_inc[5:0];
        end
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      chan_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      chan_r <= chan_nxt;
    end
  end

endmodule

// ===== rtl/mp_queue.sv =====
// Short first-in first-out queue between the front end and the back end.
module mp_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  input  logic          pop_i,
  output logic [DW-1:0] pop_data_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] slots_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign full_o     = (count_r == NW'(DEPTH));
  assign empty_o    = (count_r == '0);
  assign pop_data_o = slots_r[rd_ptr_r];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + NW'(1);
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk) begin
    if (push_i) begin
      slots_r[wr_ptr_r] <= push_data_i;
    end
  end

endmodule

// ===== rtl/mp_back.sv =====
// Back end: pair maximum, line store of pair maxima and the result stages.
module mp_back import mp_pkg::*; #(
  parameter int MAX_WIDTH = 64,
  localparam int SW = $clog2(MAX_WIDTH / 2)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic signed [SAMPLE_W-1:0]  floor_i,
  input  logic                        head_valid_i,
  input  pool_item_t                  head_item_i,
  input  logic [SW-1:0]               head_slot_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [SAMPLE_W-1:0]  out_pooled_o,
  output logic                        out_last_o
);

  localparam int SLOTS = MAX_WIDTH / 2;

  logic signed [SAMPLE_W-1:0] line_mem [SLOTS];

  logic signed [SAMPLE_W-1:0] pair_max_r, pair_max_nxt;
  logic signed [SAMPLE_W-1:0] pair_full;
  logic                       s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_W-1:0] s1_pair_r;
  logic signed [SAMPLE_W-1:0] s1_upper_r;
  logic                       s1_last_r;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_pooled_r;
  logic                       out_last_r;
  logic signed [SAMPLE_W-1:0] upper_vs_floor;
  logic signed [SAMPLE_W-1:0] window_max;
  logic                       out_free;
  logic                       s1_free;
  logic                       mem_write;
  logic                       s1_load;

  // Each stage moves when the one after it is empty or being drained.
  assign out_free = !out_valid_r || out_ready_i;
  assign s1_free  = !s1_valid_r || out_free;

  // Only a window result needs room downstream; other samples pass freely.
  assign pop_o = head_valid_i && ((head_item_i.kind != KIND_PAIR_EMIT) || s1_free);

  // Maximum of the horizontal pair closed by this sample.
  assign pair_full = (head_item_i.sample >= pair_max_r) ? head_item_i.sample : pair_max_r;

  always_comb begin
    pair_max_nxt = pair_max_r;
    mem_write    = 1'b0;
    s1_load      = 1'b0;
    if (pop_o) begin
      case (head_item_i.kind)
        KIND_PAIR_FIRST: pair_max_nxt = head_item_i.sample;
        KIND_PAIR_STORE: mem_write    = 1'b1;
        KIND_PAIR_EMIT:  s1_load      = 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Line store: pair maxima of the even row, read back on the odd row.
  always_ff @(posedge clk) begin
    if (mem_write) begin
      line_mem[head_slot_i] <= pair_full;
    end
    if (s1_load) begin
      s1_upper_r <= line_mem[head_slot_i];
      s1_pair_r  <= pair_full;
      s1_last_r  <= head_item_i.last;
    end
    pair_max_r <= pair_max_nxt;
  end

  // Window maximum, never below the floor.
  assign upper_vs_floor = (s1_upper_r >= floor_i) ? s1_upper_r : floor_i;
  assign window_max     = (s1_pair_r >= upper_vs_floor) ? s1_pair_r : upper_vs_floor;

  always_comb begin
    s1_valid_nxt  = s1_free ? s1_load : s1_valid_r;
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_pooled_r <= window_max;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid_o  = out_valid_r;
  assign out_pooled_o = out_pooled_r;
  assign out_last_o   = out_last_r;

endmodule

// ===== rtl/max_pool_2x2_stride2.sv =====
// Streaming 2x2 stride 2 max pooling, top level with configuration registers.
// A result goes through the queue, the s1 stage registers and the output register.
// Throughput: one sample per cycle unless output stalls fill the queue.
// A result waiting at the output does not stop input while the four-entry queue has room.
// Synchronous reset (rst_n low) clears counters, queue, result valids; resets config.
// The line store is not cleared; with a steady width it is written before it is read.
`include "max_pool_2x2_stride2_defines.svh"

module max_pool_2x2_stride2 import mp_pkg::*; #(
  parameter int MAX_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [SAMPLE_W-1:0]  in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_pooled,
  output logic                        out_last_of_channel,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_wdata
);

  localparam int SW          = $clog2(MAX_WIDTH / 2);
  localparam int QUEUE_DEPTH = 4;
  localparam int QW          = $bits(pool_item_t) + SW;

  logic [6:0]                 in_width_r;
  logic [6:0]                 in_height_r;
  logic [8:0]                 channel_count_r;
  logic signed [SAMPLE_W-1:0] floor_value_r;

  pool_cfg_t     geom;
  logic          in_accept;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  pool_item_t    push_item;
  logic [SW-1:0] push_slot;
  pool_item_t    head_item;
  logic [SW-1:0] head_slot;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r      <= WIDTH_RESET;
      in_height_r     <= HEIGHT_RESET;
      channel_count_r <= CHANNEL_RESET;
      floor_value_r   <= FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_IN_WIDTH:      in_width_r      <= cfg_wdata[6:0];
        REG_IN_HEIGHT:     in_height_r     <= cfg_wdata[6:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[8:0];
        REG_FLOOR_VALUE:   floor_value_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign geom.in_width      = in_width_r;
  assign geom.in_height     = in_height_r;
  assign geom.channel_count = channel_count_r;

  // A request is taken whenever the queue has room.
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  mp_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (geom),
    .in_accept_i (in_accept),
    .in_sample_i (in_sample),
    .push_o      (q_push),
    .item_o      (push_item),
    .slot_o      (push_slot)
  );

  assign q_wdata = {push_item, push_slot};

  mp_queue #(
    .DW    (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  assign head_item = pool_item_t'(q_rdata[QW-1:SW]);
  assign head_slot = q_rdata[SW-1:0];

  mp_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .floor_i      (floor_value_r),
    .head_valid_i (!q_empty),
    .head_item_i  (head_item),
    .head_slot_i  (head_slot),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_pooled_o (out_pooled),
    .out_last_o   (out_last_of_channel)
  );

  // Queue occupancy stays consistent between front and back.
  `MP_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full)
  `MP_ASSERT_IMP(a_queue_no_underflow, q_pop, !q_empty)
  `MP_ASSERT_NXT(a_queue_fills, q_push && q_empty && !q_pop, !q_empty)
  // A pooled value never lies below the floor.
  `MP_ASSERT_IMP(a_pooled_above_floor, out_valid, out_pooled >= floor_value_r)

endmodule

// ===== sim/tb_max_pool_2x2_stride2.sv =====
// Self-checking testbench for the streaming 2x2 stride 2 max pooling block.
`timescale 1ns / 1ps

module tb_max_pool_2x2_stride2;
  import mp_pkg::*;

  localparam int MAX_W          = 64;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  // How sample values are drawn.
  typedef enum int {
    DRAW_ANY,
    DRAW_NEAR_FLOOR,
    DRAW_EXTREME
  } sample_draw_t;

  // One expected pooled result.
  typedef struct {
    logic signed [SAMPLE_W-1:0] pooled;
    logic                       last;
  } pooled_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_pooled;
  logic                       out_last_of_channel;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_wdata = '0;

  // Shadow of the configuration registers.
  logic [6:0]                 cfg_width = WIDTH_RESET;
  logic [6:0]                 cfg_height = HEIGHT_RESET;
  logic [8:0]                 cfg_channels = CHANNEL_RESET;
  logic signed [SAMPLE_W-1:0] cfg_floor = FLOOR_RESET;

  // Shadow of the position counters and the pair maxima.
  int unsigned                col_pos = 0;
  int unsigned                row_pos = 0;
  int unsigned                chan_pos = 0;
  logic signed [SAMPLE_W-1:0] pair_max;
  logic signed [SAMPLE_W-1:0] line_max [MAX_W/2];

  pooled_t pending_pooled [$];
  int      mismatches = 0;
  int      items_sent = 0;
  bit      idle_on = 1'b1;
  int      stall_left = 0;
  int      quiet_cycles = 0;

  max_pool_2x2_stride2 #(
    .MAX_WIDTH(MAX_W)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pooled         (out_pooled),
    .out_last_of_channel(out_last_of_channel),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Advance the position counters by one sample and queue the window maximum it completes.
  function automatic void track_window_max(logic signed [SAMPLE_W-1:0] s);
    int unsigned w;
    int unsigned h;
    int unsigned ch;
    int unsigned span_c;
    int unsigned span_r;
    logic signed [SAMPLE_W-1:0] pair;
    pooled_t result;
    w = (cfg_width < WIDTH_MIN) ? WIDTH_MIN : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
    h = (cfg_height < HEIGHT_MIN) ? HEIGHT_MIN :
        ((cfg_height > HEIGHT_MAX) ? HEIGHT_MAX : cfg_height);
    ch = (cfg_channels < CHANNEL_MIN) ? CHANNEL_MIN :
         ((cfg_channels > CHANNEL_MAX) ? CHANNEL_MAX : cfg_channels);
    span_c = 2 * (w / 2);
    span_r = 2 * (h / 2);

    // A trailing odd column or row is consumed without touching the maxima.
    if (col_pos < span_c && row_pos < span_r) begin
      if (col_pos[0] == 1'b0) begin
        pair_max = s;
      end else begin
        pair = (s >= pair_max) ? s : pair_max;
        if (row_pos[0] == 1'b0) begin
          line_max[col_pos / 2] = pair;
        end else begin
          result.pooled = cfg_floor;
          if (line_max[col_pos / 2] >= result.pooled) result.pooled = line_max[col_pos / 2];
          if (pair >= result.pooled) result.pooled = pair;
          result.last = (col_pos == span_c - 1) && (row_pos == span_r - 1);
          pending_pooled.push_back(result);
        end
      end
    end

    // Counters wrap with a greater-or-equal compare, so a shrunken size wraps them too.
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        chan_pos = (chan_pos + 1 >= ch) ? 0 : chan_pos + 1;
      end else begin
        row_pos = row_pos + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Fill the bits above a register's width with random values.
  function automatic logic [15:0] pad_upper(logic [15:0] value, int bits);
    logic [15:0] mask;
    mask = 16'hFFFF << bits;
    return (16'($urandom) & mask) | (value & ~mask);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_draw_t mode);
    int v;
    case (mode)
      DRAW_NEAR_FLOOR: begin
        v = int'(cfg_floor) + int'($urandom_range(0, 64)) - 32;
        return SAMPLE_W'(v);
      end
      DRAW_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Send one sample request; valid stays high after acceptance until the caller moves on.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    track_window_max(s);
    items_sent++;
  endtask

  task automatic send_samples(int n, sample_draw_t mode);
    repeat (n) send_sample(pick_sample(mode));
  endtask

  task automatic send_window(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b,
                             logic signed [SAMPLE_W-1:0] c, logic signed [SAMPLE_W-1:0] d);
    send_sample(a);
    send_sample(b);
    send_sample(c);
    send_sample(d);
  endtask

  task automatic finish_channel(sample_draw_t mode);
    while (col_pos != 0 || row_pos != 0) send_sample(pick_sample(mode));
  endtask

  task automatic send_channels(int n, sample_draw_t mode);
    repeat (n) begin
      send_sample(pick_sample(mode));
      finish_channel(mode);
    end
  endtask

  // Wait until every expected result has arrived and the pipeline has emptied.
  task automatic wait_drained();
    while (pending_pooled.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IN_WIDTH:      cfg_width = data[6:0];
      REG_IN_HEIGHT:     cfg_height = data[6:0];
      REG_CHANNEL_COUNT: cfg_channels = data[8:0];
      REG_FLOOR_VALUE:   cfg_floor = data;
      default: ;
    endcase
  endtask

  // Write all four registers once the block is idle.
  task automatic set_config(logic [6:0] w, logic [6:0] h, logic [8:0] ch,
                            logic signed [SAMPLE_W-1:0] fl);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(REG_IN_WIDTH, pad_upper(16'(w), 7));
    write_reg(REG_IN_HEIGHT, pad_upper(16'(h), 7));
    write_reg(REG_CHANNEL_COUNT, pad_upper(16'(ch), 9));
    write_reg(REG_FLOOR_VALUE, fl);
    cfg_valid <= 1'b0;
  endtask

  // Reset sizes and floor, then a height shrink in the middle of a channel.
  task automatic test_reset_config();
    send_samples(52, DRAW_NEAR_FLOOR);
    set_config(7'd26, 7'd2, 9'd8, FLOOR_RESET);
    finish_channel(DRAW_NEAR_FLOOR);
  endtask

  // Sample and floor extremes, the maximum in each window position, low size saturation.
  task automatic test_extremes();
    set_config(7'd0, 7'd1, 9'd0, 16'sh8000);
    send_window(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_window(16'sh7FFF, -1, 0, 5);
    send_window(1, 9, 3, 2);
    send_window(1, 2, 9, 3);
    send_window(1, 2, 3, 9);
    send_window(-7, -7, -7, -7);
    set_config(7'd2, 7'd2, 9'd1, 16'sh7FFF);
    send_window(-5, 100, 16'sh7FFE, 0);
    set_config(7'd2, 7'd2, 9'd1, 16'sh0000);
    send_window(-1, -2, -3, -4);
  endtask

  // Trailing odd column and odd row are consumed without a result.
  task automatic test_odd_trailing();
    set_config(7'd5, 7'd3, 9'd2, 16'sh8000);
    send_channels(2, DRAW_ANY);
  endtask

  // Width and channel count shrink while the counters are beyond the new limits.
  task automatic test_shrink_mid_channel();
    set_config(7'd8, 7'd6, 9'd3, -16'sd100);
    send_samples(14, DRAW_ANY);
    set_config(7'd4, 7'd6, 9'd3, -16'sd100);
    finish_channel(DRAW_ANY);
    set_config(7'd4, 7'd4, 9'd1, -16'sd100);
    send_channels(1, DRAW_ANY);
  endtask

  // Sizes above the limits saturate to the largest width, height and channel count.
  task automatic test_size_saturation();
    set_config(7'd127, 7'd1, 9'd511, -16'sd2560);
    send_channels(1, DRAW_NEAR_FLOOR);
    set_config(7'd2, 7'd127, 9'd257, 16'sh8000);
    send_channels(1, DRAW_ANY);
  endtask

  task automatic run_random_phase();
    logic [6:0]                 w;
    logic [6:0]                 h;
    logic [8:0]                 ch;
    logic signed [SAMPLE_W-1:0] fl;
    case ($urandom_range(0, 9))
      0: begin
        w = 7'($urandom_range(33, 64));
        h = 7'($urandom_range(2, 5));
      end
      1: begin
        w = 7'($urandom_range(2, 5));
        h = 7'($urandom_range(33, 64));
      end
      2: begin
        w = 7'($urandom);
        h = 7'($urandom_range(0, 3));
      end
      default: begin
        w = 7'($urandom_range(2, 12));
        h = 7'($urandom_range(2, 12));
      end
    endcase
    ch = 9'($urandom);
    case ($urandom_range(0, 7))
      0, 1: fl = SAMPLE_W'($urandom);
      2: fl = 16'sh8000;
      3: fl = 16'sh7FFF;
      default: fl = SAMPLE_W'(int'($urandom_range(0, 4000)) - 2000);
    endcase
    set_config(w, h, ch, fl);
    send_channels($urandom_range(1, 3), sample_draw_t'($urandom_range(0, 2)));
  endtask

  // Random geometries, floors and samples, with idling switched on and off per phase.
  task automatic test_random_frames(int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      run_random_phase();
    end
  endtask

  // Full rate on both sides to close the run.
  task automatic test_quiet_tail();
    idle_on = 1'b0;
    repeat (2) run_random_phase();
  endtask

  // Output side: random stall bursts while idling is enabled.
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 15);
    out_ready <= (stall_left == 0);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_result
    pooled_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pooled.size() == 0) begin
        $error("pooled: expected no result, actual %0d", out_pooled);
        mismatches++;
      end else begin
        want = pending_pooled.pop_front();
        if (out_pooled !== want.pooled) begin
          $error("pooled: expected %0d, actual %0d", want.pooled, out_pooled);
          mismatches++;
        end
        if (out_last_of_channel !== want.last) begin
          $error("last_of_channel: expected %0d, actual %0d", want.last, out_last_of_channel);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when no request moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("max_pool_2x2_stride2: mismatch");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_extremes();
    test_odd_trailing();
    test_shrink_mid_channel();
    test_size_saturation();
    test_random_frames(750);
    test_quiet_tail();
    in_valid <= 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("max_pool_2x2_stride2: match");
    end else begin
      $display("max_pool_2x2_stride2: mismatch");
    end
    $finish;
  end

endmodule

// ===== max_pool_2x2_stride2.f =====
+incdir+rtl
rtl/mp_pkg.sv
rtl/mp_front.sv
rtl/mp_queue.sv
rtl/mp_back.sv
rtl/max_pool_2x2_stride2.sv
sim/tb_max_pool_2x2_stride2.sv
